// ===== hw/rtl/balancing_robot_posture_sequencer_core_assert.svh =====
// assertion macros for the posture sequencer checker
// used by brps_checker only, no other dependencies
`ifndef BALANCING_ROBOT_POSTURE_SEQUENCER_CORE_ASSERT_SVH
`define BALANCING_ROBOT_POSTURE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BRPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brps assertion failed");

// next-cycle implication, disabled during reset
`define BRPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brps assertion failed");

`endif

// ===== hw/rtl/brps_pkg.sv =====
// types, register codes and reset values for the posture sequencer
// no dependencies
`timescale 1ns / 1ps

package brps_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] RegRaiseStepTicks = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegLowerStepTicks = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegServoStartPos  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegRaiseLimitPos  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegLeanPos        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegArmHoldTicks   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegTipAngle       = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegSleepAngle     = 3'd7;

   localparam logic [7:0] CmdPosture = 8'h05;

   localparam logic signed [17:0] VerticalBand  = 18'sd128;
   localparam logic signed [17:0] LeanDoneAngle = 18'sd512;

   localparam logic [7:0] HoldReset = 8'd100;

   localparam logic [1:0] ArmNone = 2'd0;
   localparam logic [1:0] ArmOne  = 2'd1;
   localparam logic [1:0] ArmTwo  = 2'd2;

   typedef struct packed {
      logic signed [16:0] tilt_angle;
      logic [7:0]         radio_byte;
      logic [7:0]         serial_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] servo_one_pulse;
      logic [7:0] servo_two_pulse;
      logic       radio_enable;
      logic       flush_radio;
      logic       controller_reset;
      logic       is_balancing;
      logic       is_standing;
      logic       is_sleeping;
      logic       lean_forward;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  raise_step_ticks;
      logic [7:0]  lower_step_ticks;
      logic [7:0]  servo_start_pos;
      logic [7:0]  raise_limit_pos;
      logic [7:0]  lean_pos;
      logic [7:0]  arm_hold_ticks;
      logic [15:0] tip_angle;
      logic [15:0] sleep_angle;
   } cfg_type;

   typedef struct packed {
      logic       balancing_flag;
      logic       standing_flag;
      logic       sleeping_flag;
      logic [7:0] servo_position;
      logic [7:0] step_divider;
      logic [1:0] arm_select;
      logic [7:0] arm_hold_count;
      logic [7:0] servo_one_compare;
      logic [7:0] servo_two_compare;
      logic       radio_enable_level;
   } state_type;

   localparam cfg_type CfgReset = '{
      raise_step_ticks: 8'd20,
      lower_step_ticks: 8'd30,
      servo_start_pos:  8'd25,
      raise_limit_pos:  8'd120,
      lean_pos:         8'd93,
      arm_hold_ticks:   8'd100,
      tip_angle:        16'd7680,
      sleep_angle:      16'd20992
   };

   localparam state_type StateReset = '{
      balancing_flag:     1'b0,
      standing_flag:      1'b0,
      sleeping_flag:      1'b0,
      servo_position:     8'd0,
      step_divider:       8'd0,
      arm_select:         ArmNone,
      arm_hold_count:     HoldReset,
      servo_one_compare:  8'd0,
      servo_two_compare:  8'd0,
      radio_enable_level: 1'b1
   };

endpackage

// ===== hw/rtl/brps_cfg_regs.sv =====
// configuration register file of the posture sequencer
// depends on brps_pkg
`timescale 1ns / 1ps

module brps_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [brps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [brps_pkg::CsrDataWidth-1:0]   csr_write_data,
   output brps_pkg::cfg_type                   cfg
);

   brps_pkg::cfg_type cfg_ff;
   brps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            brps_pkg::RegRaiseStepTicks: cfg_in.raise_step_ticks = csr_write_data[7:0];
            brps_pkg::RegLowerStepTicks: cfg_in.lower_step_ticks = csr_write_data[7:0];
            brps_pkg::RegServoStartPos:  cfg_in.servo_start_pos  = csr_write_data[7:0];
            brps_pkg::RegRaiseLimitPos:  cfg_in.raise_limit_pos  = csr_write_data[7:0];
            brps_pkg::RegLeanPos:        cfg_in.lean_pos         = csr_write_data[7:0];
            brps_pkg::RegArmHoldTicks:   cfg_in.arm_hold_ticks   = csr_write_data[7:0];
            brps_pkg::RegTipAngle:       cfg_in.tip_angle        = csr_write_data;
            brps_pkg::RegSleepAngle:     cfg_in.sleep_angle      = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= brps_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/brps_tick_logic.sv =====
// next-state and result logic for one control tick
// depends on brps_pkg
`timescale 1ns / 1ps

module brps_tick_logic (
   input  brps_pkg::req_type   req,
   input  brps_pkg::cfg_type   cfg,
   input  brps_pkg::state_type state_cur,
   output brps_pkg::state_type state_nxt,
   output brps_pkg::rsp_type   rsp
);

   logic signed [17:0] ang;
   logic signed [17:0] tip_pos;
   logic signed [17:0] tip_neg;
   logic signed [17:0] lie;

   assign ang     = {req.tilt_angle[16], req.tilt_angle};
   assign tip_pos = {2'b00, cfg.tip_angle};
   assign tip_neg = -tip_pos;
   assign lie     = {2'b00, cfg.sleep_angle};

   always_comb begin
      brps_pkg::state_type s;
      logic                flush;
      logic                ctl_reset;
      logic                lean;
      logic [7:0]          hold_val;

      s         = state_cur;
      flush     = 1'b0;
      ctl_reset = 1'b0;
      lean      = 1'b0;
      hold_val  = 8'd0;

      // command check
      if (!s.standing_flag && !s.sleeping_flag &&
          (req.radio_byte == brps_pkg::CmdPosture ||
           req.serial_byte == brps_pkg::CmdPosture)) begin
         if (!s.balancing_flag) begin
            s.standing_flag  = 1'b1;
            s.arm_hold_count = 8'd0;
         end else begin
            s.sleeping_flag = 1'b1;
         end
         s.radio_enable_level = 1'b0;
         flush                = 1'b1;
         s.servo_position     = cfg.servo_start_pos;
         s.step_divider       = 8'd0;
      end

      // posture ramp
      if (!s.balancing_flag && s.standing_flag) begin
         if (s.step_divider == cfg.raise_step_ticks) begin
            if (ang > 18'sd0) begin
               s.arm_select        = brps_pkg::ArmOne;
               s.servo_one_compare = s.servo_position;
            end else if (ang < 18'sd0) begin
               s.arm_select        = brps_pkg::ArmTwo;
               s.servo_two_compare = s.servo_position;
            end
            if (s.servo_position < cfg.raise_limit_pos) begin
               s.servo_position = s.servo_position + 8'd1;
            end
            s.step_divider = 8'd0;
         end else begin
            s.step_divider = s.step_divider + 8'd1;
         end
      end else if (s.balancing_flag && s.sleeping_flag) begin
         if (s.step_divider == cfg.raise_step_ticks) begin
            if (s.servo_position < cfg.lean_pos) begin
               s.servo_position    = s.servo_position + 8'd1;
               s.servo_one_compare = s.servo_position;
            end
            s.step_divider = 8'd0;
         end
         if (s.servo_position == cfg.lean_pos) begin
            lean = 1'b1;
            if (ang > brps_pkg::LeanDoneAngle) begin
               s.balancing_flag = 1'b0;
               s.step_divider   = 8'd0;
            end
         end else begin
            s.step_divider = s.step_divider + 8'd1;
         end
      end else if (!s.balancing_flag && s.sleeping_flag) begin
         if (s.step_divider == cfg.lower_step_ticks) begin
            if (ang <= lie) begin
               if (s.servo_position != 8'd0) begin
                  s.servo_position = s.servo_position - 8'd1;
               end
               s.servo_one_compare = s.servo_position;
            end
            s.step_divider = 8'd0;
         end
         if (ang > lie) begin
            s.sleeping_flag      = 1'b0;
            s.servo_one_compare  = 8'd0;
            s.radio_enable_level = 1'b1;
         end else begin
            s.step_divider = s.step_divider + 8'd1;
         end
      end

      // vertical check
      if (!s.balancing_flag && ang > -brps_pkg::VerticalBand &&
          ang < brps_pkg::VerticalBand) begin
         s.standing_flag      = 1'b0;
         s.balancing_flag     = 1'b1;
         s.radio_enable_level = 1'b1;
      end

      // arm retract, pulse released on the last hold tick
      if (s.balancing_flag && s.arm_hold_count < cfg.arm_hold_ticks) begin
         s.arm_hold_count = s.arm_hold_count + 8'd1;
         hold_val = (s.arm_hold_count == cfg.arm_hold_ticks) ? 8'd0 : cfg.servo_start_pos;
         case (s.arm_select)
            brps_pkg::ArmOne: s.servo_one_compare = hold_val;
            brps_pkg::ArmTwo: s.servo_two_compare = hold_val;
            default: s.arm_select = s.arm_select;
         endcase
      end

      // tip check
      if (ang > tip_pos || ang < tip_neg || !s.balancing_flag) begin
         ctl_reset        = 1'b1;
         s.balancing_flag = 1'b0;
      end

      state_nxt                = s;
      rsp.servo_one_pulse      = s.servo_one_compare;
      rsp.servo_two_pulse      = s.servo_two_compare;
      rsp.radio_enable         = s.radio_enable_level;
      rsp.flush_radio          = flush;
      rsp.controller_reset     = ctl_reset;
      rsp.is_balancing         = s.balancing_flag;
      rsp.is_standing          = s.standing_flag;
      rsp.is_sleeping          = s.sleeping_flag;
      rsp.lean_forward         = lean;
   end

endmodule

// ===== hw/rtl/balancing_robot_posture_sequencer_core.sv =====
// posture sequencer core: input register, tick logic, result register
// an rsp word is computed from the req register and captured in the rsp register once that is free
// throughput: one word per cycle while rsp_stall is low; the rsp register frees as it is taken
// reset: synchronous, active high; loads reset values into flags, counters, compares and config
// depends on brps_pkg, brps_cfg_regs, brps_tick_logic
`timescale 1ns / 1ps

module balancing_robot_posture_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  brps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output brps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [brps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [brps_pkg::CsrDataWidth-1:0]   csr_write_data
);

   brps_pkg::cfg_type   cfg;
   brps_pkg::state_type state_ff;
   brps_pkg::state_type state_in;
   brps_pkg::req_type   req_ff;
   brps_pkg::rsp_type   rsp_ff;
   brps_pkg::rsp_type   rsp_in;
   logic                req_valid_ff;
   logic                req_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_free;
   logic                advance;
   logic                accept;

   brps_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   brps_tick_logic u_tick_logic (
      .req       (req_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_free;
   assign req_stall = req_valid_ff && !rsp_free;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= brps_pkg::StateReset;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/brps_checker.sv =====
// port-level checks for the posture sequencer core, bound to the top level
// depends on brps_pkg and balancing_robot_posture_sequencer_core_assert.svh
`timescale 1ns / 1ps
`include "balancing_robot_posture_sequencer_core_assert.svh"

module brps_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input brps_pkg::rsp_type rsp_data
);

   // standing and sleeping sequences exclude each other
   `BRPS_ASSERT_SAME(a_seq_exclusive, clock, reset, rsp_valid, !(rsp_data.is_standing && rsp_data.is_sleeping))

   // controller held in reset exactly when not balancing
   `BRPS_ASSERT_SAME(a_reset_vs_balance, clock, reset, rsp_valid, rsp_data.controller_reset != rsp_data.is_balancing)

   // forward lean only during the sleep sequence
   `BRPS_ASSERT_SAME(a_lean_in_sleep, clock, reset, rsp_valid && rsp_data.lean_forward, rsp_data.is_sleeping)

   // stalled word holds
   `BRPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind balancing_robot_posture_sequencer_core brps_checker u_brps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
